// ===== rtl/core/rssw_pkg.sv =====
// Shared types, constants and helper functions for the request statistics core.
package rssw_pkg;

  localparam int BUCKETS_DEF        = 60;
  localparam int DEFAULT_WINDOW_DEF = 5;
  localparam int TIME_BITS_DEF      = 32;

  localparam int IN_TDATA_W  = 56;
  localparam int OUT_TDATA_W = 544;

  localparam int CTR_W     = 64;
  localparam int NUM_SLOTS = 9;
  localparam int SLOT_W    = 4;

  localparam logic [SLOT_W-1:0] SLOT_UNKNOWN = 4'd8;

  localparam logic [7:0] CODE_READ_COILS      = 8'h01;
  localparam logic [7:0] CODE_READ_DISCRETE   = 8'h02;
  localparam logic [7:0] CODE_READ_HOLDING    = 8'h03;
  localparam logic [7:0] CODE_READ_INPUT      = 8'h04;
  localparam logic [7:0] CODE_WRITE_COIL      = 8'h05;
  localparam logic [7:0] CODE_WRITE_REGISTER  = 8'h06;
  localparam logic [7:0] CODE_WRITE_COILS     = 8'h0F;
  localparam logic [7:0] CODE_WRITE_REGISTERS = 8'h10;

  typedef enum logic [1:0] {
    CMD_RECORD = 2'd0,
    CMD_TICK   = 2'd1,
    CMD_QUERY  = 2'd2,
    CMD_CLEAR  = 2'd3
  } cmd_t;

  function automatic logic [SLOT_W-1:0] slot_of_code(input logic [7:0] code);
    logic [SLOT_W-1:0] slot;
    case (code)
      CODE_READ_COILS:      slot = 4'd0;
      CODE_READ_DISCRETE:   slot = 4'd1;
      CODE_READ_HOLDING:    slot = 4'd2;
      CODE_READ_INPUT:      slot = 4'd3;
      CODE_WRITE_COIL:      slot = 4'd4;
      CODE_WRITE_REGISTER:  slot = 4'd5;
      CODE_WRITE_COILS:     slot = 4'd6;
      CODE_WRITE_REGISTERS: slot = 4'd7;
      default:              slot = SLOT_UNKNOWN;
    endcase
    return slot;
  endfunction

endpackage

// ===== rtl/core/request_stats_sliding_window_core.sv =====
// Request statistics core: cumulative totals, function-code counters and a minute-bucket window.
//
// Input channel (in_*): one transfer per command, selected by in_tuser. A record adds one
// request to the totals, to its function-code counter and to the current bucket. A tick
// advances the bucket ring and empties the bucket it enters. A query sums the newest N
// buckets and returns one function-code counter. A clear empties the totals and all buckets
// and keeps the function-code counters and the ring position.
// Output channel (out_*): exactly one result transfer per input transfer, in order.
// A tick or a clear goes from the accepting state straight to the output state. A record
// reads the bucket and counter memories as it is taken and writes them back in a record state
// (read, modify and write). A query sums the newest N buckets through the single read port of
// the bucket memory, one bucket a cycle, before it passes to the output state.
// A new input transfer is taken once the previous result sits in the output register, so
// the input side proceeds while the receiver holds off; with a stalled receiver the block
// waits with its next result ready until the output register frees.
// Reset empties all buckets and counters at once through per-entry valid bits, so the block
// takes input transfers in the first cycle after reset.
module request_stats_sliding_window_core #(
  parameter int BUCKETS        = rssw_pkg::BUCKETS_DEF,
  parameter int DEFAULT_WINDOW = rssw_pkg::DEFAULT_WINDOW_DEF,
  parameter int TIME_BITS      = rssw_pkg::TIME_BITS_DEF
) (
  input  logic                               clk,
  input  logic                               rst_n,
  input  logic                               in_tvalid,
  output logic                               in_tready,
  // fn_code[7:0], success[8], resp_time[40:9], window_minutes[48:41], fc_slot[52:49].
  input  logic [rssw_pkg::IN_TDATA_W-1:0]    in_tdata,
  // command[1:0].
  input  logic [1:0]                         in_tuser,
  output logic                               out_tvalid,
  input  logic                               out_tready,
  // req_count[63:0], fail_count[127:64], response_sum[191:128],
  // max_response[223:192], min_response[255:224], code_count[319:256],
  // window_requests[383:320], window_failures[447:384], window_response_sum[511:448],
  // window_samples[543:512].
  output logic [rssw_pkg::OUT_TDATA_W-1:0]   out_tdata
);

  localparam int IW    = $clog2(BUCKETS);
  localparam int CW    = $clog2(BUCKETS + 1);
  localparam int DEF_N = (DEFAULT_WINDOW > BUCKETS) ? BUCKETS : DEFAULT_WINDOW;
  localparam int SW    = rssw_pkg::SLOT_W;

  typedef struct packed {
    logic [31:0] samples;
    logic [63:0] time_sum;
    logic [31:0] failures;
    logic [31:0] requests;
  } bucket_t;

  typedef enum logic [1:0] {
    S_IDLE,
    S_REC,
    S_QRY,
    S_OUT
  } state_t;

  state_t state_r, state_nxt;

  rssw_pkg::cmd_t cmd_in, cmd_r;
  logic [7:0]     fc_in;
  logic           ok_in, ok_r;
  logic [31:0]    resp_in;
  logic [63:0]    resp64;
  logic [7:0]     win_in;
  logic [SW-1:0]  slot_in;
  logic [TIME_BITS-1:0] t_in, t_r;
  logic           accept;
  logic           win_ok;
  logic [CW-1:0]  n_in;

  logic [IW-1:0]  cb_r, cb_inc, ptr_r, ptr_prev;
  logic [CW-1:0]  left_r;
  logic           pend_r;
  logic [BUCKETS-1:0] bkt_vld_r;
  logic           bkt_hit_r;
  logic           bkt_re, bkt_we;
  logic [IW-1:0]  bkt_raddr;
  bucket_t        bkt_rdata, bkt_cur, bkt_upd;

  logic [rssw_pkg::NUM_SLOTS-1:0] cc_vld_r;
  logic           cc_hit_r;
  logic           cc_re, cc_we;
  logic [SW-1:0]  cc_raddr, slot_r;
  logic           slot_ok_r;
  logic [63:0]    cc_rdata, cc_cur;

  logic [63:0]    req_tot_r, fail_tot_r, time_tot_r;
  logic [TIME_BITS-1:0] large_r, small_r;
  logic [63:0]    large64, small64;
  logic [63:0]    w_req_r, w_fail_r, w_sum_r;
  logic [31:0]    w_cnt_r;
  logic [63:0]    code_count;

  logic           out_tvalid_r;
  logic [rssw_pkg::OUT_TDATA_W-1:0] out_tdata_r;
  logic           out_free;

  assign cmd_in  = rssw_pkg::cmd_t'(in_tuser);
  assign fc_in   = in_tdata[7:0];
  assign ok_in   = in_tdata[8];
  assign resp_in = in_tdata[40:9];
  assign win_in  = in_tdata[48:41];
  assign slot_in = in_tdata[52:49];
  assign resp64  = {32'd0, resp_in};
  assign t_in    = resp64[TIME_BITS-1:0];

  assign in_tready = (state_r == S_IDLE);
  assign accept    = in_tvalid && in_tready;

  assign win_ok = (win_in != 8'd0) && ({1'b0, win_in} <= 9'(BUCKETS));
  assign n_in   = win_ok ? CW'(win_in) : CW'(DEF_N);

  assign cb_inc   = (cb_r == IW'(BUCKETS - 1)) ? '0 : cb_r + 1'b1;
  assign ptr_prev = (ptr_r == '0) ? IW'(BUCKETS - 1) : ptr_r - 1'b1;

  assign bkt_re    = (accept && cmd_in == rssw_pkg::CMD_RECORD) ||
                     (state_r == S_QRY && left_r != '0);
  assign bkt_raddr = (state_r == S_QRY) ? ptr_r : cb_r;
  assign bkt_we    = (state_r == S_REC);
  assign bkt_cur   = bkt_hit_r ? bkt_rdata : '0;

  always_comb begin
    bkt_upd          = bkt_cur;
    bkt_upd.requests = bkt_cur.requests + 32'd1;
    bkt_upd.failures = bkt_cur.failures + {31'd0, !ok_r};
    bkt_upd.time_sum = bkt_cur.time_sum + 64'(t_r);
    bkt_upd.samples  = bkt_cur.samples + 32'd1;
  end

  rssw_ram #(
    .WIDTH ($bits(bucket_t)),
    .DEPTH (BUCKETS)
  ) u_bucket_ram (
    .clk   (clk),
    .we    (bkt_we),
    .waddr (cb_r),
    .wdata (bkt_upd),
    .re    (bkt_re),
    .raddr (bkt_raddr),
    .rdata (bkt_rdata)
  );

  assign cc_re    = accept && (cmd_in == rssw_pkg::CMD_RECORD || cmd_in == rssw_pkg::CMD_QUERY);
  assign cc_raddr = (cmd_in == rssw_pkg::CMD_RECORD) ? rssw_pkg::slot_of_code(fc_in) :
                    ((slot_in <= rssw_pkg::SLOT_UNKNOWN) ? slot_in : '0);
  assign cc_we    = (state_r == S_REC);
  assign cc_cur   = cc_hit_r ? cc_rdata : '0;

  rssw_ram #(
    .WIDTH (rssw_pkg::CTR_W),
    .DEPTH (rssw_pkg::NUM_SLOTS)
  ) u_code_ram (
    .clk   (clk),
    .we    (cc_we),
    .waddr (slot_r),
    .wdata (cc_cur + 64'd1),
    .re    (cc_re),
    .raddr (cc_raddr),
    .rdata (cc_rdata)
  );

  always_ff @(posedge clk) begin
    if (bkt_re) begin
      bkt_hit_r <= bkt_vld_r[bkt_raddr];
    end
    if (cc_re) begin
      cc_hit_r <= cc_vld_r[cc_raddr];
    end
  end

  assign out_free   = !out_tvalid_r || out_tready;
  assign large64    = 64'(large_r);
  assign small64    = 64'(small_r);
  assign code_count = (cmd_r == rssw_pkg::CMD_QUERY && slot_ok_r) ? cc_cur : 64'd0;

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      S_IDLE: begin
        if (accept) begin
          case (cmd_in)
            rssw_pkg::CMD_RECORD: state_nxt = S_REC;
            rssw_pkg::CMD_QUERY:  state_nxt = S_QRY;
            default:              state_nxt = S_OUT;
          endcase
        end
      end
      S_REC: state_nxt = S_OUT;
      S_QRY: begin
        if (left_r == '0 && !pend_r) begin
          state_nxt = S_OUT;
        end
      end
      S_OUT: begin
        if (out_free) begin
          state_nxt = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= S_IDLE;
      cb_r         <= '0;
      bkt_vld_r    <= '0;
      cc_vld_r     <= '0;
      req_tot_r    <= '0;
      fail_tot_r   <= '0;
      time_tot_r   <= '0;
      large_r      <= '0;
      small_r      <= '1;
      left_r       <= '0;
      pend_r       <= 1'b0;
      out_tvalid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      if (out_tvalid_r && out_tready && state_r != S_OUT) begin
        out_tvalid_r <= 1'b0;
      end
      case (state_r)
        S_IDLE: begin
          if (accept) begin
            cmd_r     <= cmd_in;
            ok_r      <= ok_in;
            t_r       <= t_in;
            slot_r    <= cc_raddr;
            slot_ok_r <= (slot_in <= rssw_pkg::SLOT_UNKNOWN);
            ptr_r     <= cb_r;
            left_r    <= (cmd_in == rssw_pkg::CMD_QUERY) ? n_in : '0;
            pend_r    <= 1'b0;
            w_req_r   <= '0;
            w_fail_r  <= '0;
            w_sum_r   <= '0;
            w_cnt_r   <= '0;
            case (cmd_in)
              rssw_pkg::CMD_TICK: begin
                cb_r              <= cb_inc;
                bkt_vld_r[cb_inc] <= 1'b0;
              end
              rssw_pkg::CMD_CLEAR: begin
                bkt_vld_r  <= '0;
                req_tot_r  <= '0;
                fail_tot_r <= '0;
                time_tot_r <= '0;
                large_r    <= '0;
                small_r    <= '1;
              end
              default: begin
              end
            endcase
          end
        end
        S_REC: begin
          bkt_vld_r[cb_r]  <= 1'b1;
          cc_vld_r[slot_r] <= 1'b1;
          req_tot_r        <= req_tot_r + 64'd1;
          fail_tot_r       <= fail_tot_r + {63'd0, !ok_r};
          time_tot_r       <= time_tot_r + 64'(t_r);
          if (t_r > large_r) begin
            large_r <= t_r;
          end
          if (t_r < small_r) begin
            small_r <= t_r;
          end
        end
        S_QRY: begin
          pend_r <= (left_r != '0);
          if (left_r != '0) begin
            ptr_r  <= ptr_prev;
            left_r <= left_r - 1'b1;
          end
          if (pend_r) begin
            w_req_r  <= w_req_r + 64'(bkt_cur.requests);
            w_fail_r <= w_fail_r + 64'(bkt_cur.failures);
            w_sum_r  <= w_sum_r + bkt_cur.time_sum;
            w_cnt_r  <= w_cnt_r + bkt_cur.samples;
          end
        end
        S_OUT: begin
          if (out_free) begin
            out_tvalid_r <= 1'b1;
            out_tdata_r  <= {w_cnt_r, w_sum_r, w_fail_r, w_req_r, code_count,
                             small64[31:0], large64[31:0], time_tot_r, fail_tot_r, req_tot_r};
          end
        end
        default: begin
        end
      endcase
    end
  end

  assign out_tvalid = out_tvalid_r;
  assign out_tdata  = out_tdata_r;

  assert property (@(posedge clk) disable iff (!rst_n)
    cb_r <= IW'(BUCKETS - 1))
    else $error("Current bucket index left the ring.");

  assert property (@(posedge clk) disable iff (!rst_n)
    left_r <= CW'(BUCKETS))
    else $error("Query window longer than the ring.");

  assert property (@(posedge clk) disable iff (!rst_n)
    (accept && cmd_in == rssw_pkg::CMD_CLEAR) |=> (bkt_vld_r == '0 && req_tot_r == '0))
    else $error("Clear did not empty the buckets and totals.");

  assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_REC) |=> (req_tot_r == $past(req_tot_r) + 64'd1) && bkt_vld_r[cb_r])
    else $error("Record did not update the total and the current bucket.");

  assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_IDLE && req_tot_r != '0) |-> (small_r <= large_r))
    else $error("Smallest response time above largest.");

endmodule

// ===== rtl/core/rssw_ram.sv =====
// Generic simple dual-port RAM with one write port and one registered read port.
module rssw_ram #(
  parameter int WIDTH = rssw_pkg::CTR_W,
  parameter int DEPTH = rssw_pkg::BUCKETS_DEF
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule
